// ===== sv/crr_pkg.sv =====
// shared types for the residue-to-integer reconstruction block
package crr_pkg;

  localparam int unsigned NUM_BASE_REGS = 4;
  localparam int unsigned NUM_REGS      = 5;
  localparam int unsigned FIELD_BITS    = 16;
  localparam int unsigned VALUE_BITS    = 64;

  // register indexes on the configuration port
  localparam logic [2:0] REG_BASE_0     = 3'd0;
  localparam logic [2:0] REG_BASE_1     = 3'd1;
  localparam logic [2:0] REG_BASE_2     = 3'd2;
  localparam logic [2:0] REG_BASE_3     = 3'd3;
  localparam logic [2:0] REG_BASE_COUNT = 3'd4;

  typedef struct packed {
    logic [FIELD_BITS-1:0] residue_0;
    logic [FIELD_BITS-1:0] residue_1;
    logic [FIELD_BITS-1:0] residue_2;
    logic [FIELD_BITS-1:0] residue_3;
  } crr_in_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  error;
  } crr_out_t;

endpackage

// ===== sv/crr_sermul.sv =====
// bit-serial shift-add multiplier, wide operand times narrow operand, msb first
module crr_sermul #(
  parameter int unsigned A_W = 64,
  parameter int unsigned B_W = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           go_i,
  input  logic [A_W-1:0] a_i,
  input  logic [B_W-1:0] b_i,
  output logic           done_o,
  output logic [A_W-1:0] prod_o
);

  localparam int unsigned CW = $clog2(B_W + 1);

  logic [A_W-1:0] a_q, acc_q;
  logic [B_W-1:0] b_q;
  logic [CW-1:0]  cnt_q;
  logic           busy_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(B_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= {acc_q[A_W-2:0], 1'b0} + (b_q[B_W-1] ? a_q : '0);
      b_q   <= {b_q[B_W-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== sv/crr_serdiv.sv =====
// bit-serial restoring divider, wide dividend by narrow nonzero divisor
module crr_serdiv #(
  parameter int unsigned DVD_W = 64,
  parameter int unsigned DVS_W = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             go_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quot_o,
  output logic [DVS_W-1:0] rem_o
);

  localparam int unsigned CW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_q;
  logic [DVS_W-1:0] dvs_q, rem_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
      dvd_q <= {dvd_q[DVD_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;
  assign rem_o  = rem_q;

endmodule

// ===== sv/chinese_remainder_reconstruct.sv =====
// residue-to-integer reconstruction by the chinese remainder theorem
//
//  port group   direction  handshake        word
//  in_*         in         valid / ready    crr_in_t, four residues
//  out_*        out        valid / ready    crr_out_t, value and error flag
//  p*           in / out   apb, pready = 1  base_0..base_3, base_count
//
//  one word at a time; the modular multiply-accumulate doubles, then adds the weight
//  if the residue bit is set, one residue bit per doubling and add, one 64-bit add
//  and compare per step
//  the first word after reset or any register write first runs the weight setup:
//  per modulus a product multiply, two serial divisions, one serial division per
//  euclid step and a weight multiply
//  reset clears control state; the moduli reset to 1 and the count to 1
//  a finished word waits in the output register while the next word is accepted
module chinese_remainder_reconstruct #(
  parameter int unsigned MAX_BASES = 4,
  parameter int unsigned BASE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  crr_pkg::crr_in_t       in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output crr_pkg::crr_out_t      out_data_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [4:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int unsigned VW  = crr_pkg::VALUE_BITS;
  localparam int unsigned FW  = crr_pkg::FIELD_BITS;
  localparam int unsigned B   = BASE_BITS;
  localparam int unsigned WIW = (MAX_BASES > 1) ? $clog2(MAX_BASES) : 1;
  localparam int unsigned KW  = $clog2(BASE_BITS);
  localparam logic [FW-1:0] BMASK = FW'((32'd1 << BASE_BITS) - 32'd1);

  typedef enum logic [4:0] {
    S_IDLE, S_PMUL, S_PMULW, S_COFDIV, S_COFW, S_REDW, S_ECHK, S_EDIVW, S_EUPD,
    S_EEND, S_WMULW, S_PEND, S_MLOAD, S_MDBL, S_MADD, S_MSUM, S_FIN
  } state_e;

  // (a + b) mod m for a, b below m
  function automatic logic [VW-1:0] add_mod(input logic [VW-1:0] a,
                                            input logic [VW-1:0] b,
                                            input logic [VW-1:0] m);
    logic [VW-1:0] room;
    room = m - b;
    return (a >= room) ? a - room : a + b;
  endfunction

  // configuration registers
  logic [FW-1:0] base_q [crr_pkg::NUM_BASE_REGS];
  logic [2:0]    cnt_q;
  logic          cfg_wr;
  logic [2:0]    cfg_idx;

  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready
                   && (cfg_idx < 3'(crr_pkg::NUM_REGS));
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < crr_pkg::NUM_BASE_REGS; j++) base_q[j] <= FW'(1);
      cnt_q <= 3'd1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        crr_pkg::REG_BASE_0:     base_q[0] <= pwdata[FW-1:0] & BMASK;
        crr_pkg::REG_BASE_1:     base_q[1] <= pwdata[FW-1:0] & BMASK;
        crr_pkg::REG_BASE_2:     base_q[2] <= pwdata[FW-1:0] & BMASK;
        crr_pkg::REG_BASE_3:     base_q[3] <= pwdata[FW-1:0] & BMASK;
        crr_pkg::REG_BASE_COUNT: cnt_q     <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      crr_pkg::REG_BASE_0:     prdata = 32'(base_q[0]);
      crr_pkg::REG_BASE_1:     prdata = 32'(base_q[1]);
      crr_pkg::REG_BASE_2:     prdata = 32'(base_q[2]);
      crr_pkg::REG_BASE_3:     prdata = 32'(base_q[3]);
      crr_pkg::REG_BASE_COUNT: prdata = 32'(cnt_q);
      default:                 prdata = '0;
    endcase
  end

  // moduli in use: zero counts as one, clamp to MAX_BASES
  logic [2:0] n_w;
  always_comb begin
    if (cnt_q == 3'd0) n_w = 3'd1;
    else if (cnt_q > 3'(MAX_BASES)) n_w = 3'(MAX_BASES);
    else n_w = cnt_q;
  end

  // control and datapath state
  state_e               state_q;
  logic [2:0]           i_q;
  logic                 wv_q, cf_q, fail_q, out_valid_q, err_q;
  logic [VW-1:0]        prod_q, cof_q, acc_q, t_q;
  logic [VW-1:0]        w_q [MAX_BASES];
  logic [FW-1:0]        res_q [crr_pkg::NUM_BASE_REGS];
  logic [KW-1:0]        k_q;
  logic [B-1:0]         r0_q, r1_q, q_q;
  logic signed [B+1:0]  t0_q, t1_q;
  crr_pkg::crr_out_t    out_q;

  // serial unit handshakes
  logic          mul_go_q, mul_done, div_go_q, div_done;
  logic [VW-1:0] mul_a_q, mul_prod, div_dvd_q, div_quot;
  logic [B-1:0]  mul_b_q, div_dvs_q, div_rem;

  crr_sermul #(.A_W(VW), .B_W(B)) u_mul (
    .clk_i (clk_i), .rst_ni (rst_ni), .go_i (mul_go_q),
    .a_i (mul_a_q), .b_i (mul_b_q), .done_o (mul_done), .prod_o (mul_prod)
  );

  crr_serdiv #(.DVD_W(VW), .DVS_W(B)) u_div (
    .clk_i (clk_i), .rst_ni (rst_ni), .go_i (div_go_q),
    .dividend_i (div_dvd_q), .divisor_i (div_dvs_q),
    .done_o (div_done), .quot_o (div_quot), .rem_o (div_rem)
  );

  // current modulus, weight and residue bit
  logic [B-1:0]             m_w;
  logic [VW-1:0]            w_w;
  logic                     rbit_w;
  logic signed [2*B+3:0]    qt_w;
  logic signed [B+1:0]      inv_s;
  logic [B-1:0]             inv_w;

  assign m_w    = base_q[i_q[1:0]][B-1:0];
  assign w_w    = w_q[i_q[WIW-1:0]];
  assign rbit_w = res_q[i_q[1:0]][k_q];
  assign qt_w   = $signed({1'b0, q_q}) * t1_q;
  // euclid coefficient folded into [0, m)
  assign inv_s  = (t0_q < 0) ? t0_q + $signed({2'b00, m_w}) : t0_q;
  assign inv_w  = inv_s[B-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wv_q        <= 1'b0;
      cf_q        <= 1'b0;
      out_valid_q <= 1'b0;
      mul_go_q    <= 1'b0;
      div_go_q    <= 1'b0;
      prod_q      <= VW'(1);
      i_q         <= '0;
      fail_q      <= 1'b0;
    end else begin
      mul_go_q <= 1'b0;
      div_go_q <= 1'b0;
      if (cfg_wr) wv_q <= 1'b0;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            res_q[0] <= in_data_i.residue_0 & BMASK;
            res_q[1] <= in_data_i.residue_1 & BMASK;
            res_q[2] <= in_data_i.residue_2 & BMASK;
            res_q[3] <= in_data_i.residue_3 & BMASK;
            i_q      <= '0;
            acc_q    <= '0;
            if (!wv_q) begin
              prod_q  <= VW'(1);
              fail_q  <= 1'b0;
              state_q <= S_PMUL;
            end else begin
              state_q <= S_MLOAD;
            end
          end
        end
        // product of the moduli in use, a zero modulus flags failure
        S_PMUL: begin
          if (i_q == n_w) begin
            i_q     <= '0;
            state_q <= fail_q ? S_PEND : S_COFDIV;
          end else if (m_w == '0) begin
            fail_q <= 1'b1;
            i_q    <= i_q + 1'b1;
          end else begin
            mul_go_q <= 1'b1;
            mul_a_q  <= prod_q;
            mul_b_q  <= m_w;
            state_q  <= S_PMULW;
          end
        end
        S_PMULW: begin
          if (mul_done) begin
            prod_q  <= mul_prod;
            i_q     <= i_q + 1'b1;
            state_q <= S_PMUL;
          end
        end
        // cofactor, then cofactor mod m
        S_COFDIV: begin
          if (i_q == n_w) begin
            state_q <= S_PEND;
          end else begin
            div_go_q  <= 1'b1;
            div_dvd_q <= prod_q;
            div_dvs_q <= m_w;
            state_q   <= S_COFW;
          end
        end
        S_COFW: begin
          if (div_done) begin
            cof_q     <= div_quot;
            div_go_q  <= 1'b1;
            div_dvd_q <= div_quot;
            div_dvs_q <= m_w;
            state_q   <= S_REDW;
          end
        end
        S_REDW: begin
          if (div_done) begin
            r0_q    <= m_w;
            r1_q    <= div_rem;
            t0_q    <= '0;
            t1_q    <= (B+2)'(1);
            state_q <= S_ECHK;
          end
        end
        // extended euclid, one serial division per step
        S_ECHK: begin
          if (r1_q == '0) begin
            state_q <= S_EEND;
          end else begin
            div_go_q  <= 1'b1;
            div_dvd_q <= VW'(r0_q);
            div_dvs_q <= r1_q;
            state_q   <= S_EDIVW;
          end
        end
        S_EDIVW: begin
          if (div_done) begin
            q_q     <= div_quot[B-1:0];
            r0_q    <= r1_q;
            r1_q    <= div_rem;
            state_q <= S_EUPD;
          end
        end
        S_EUPD: begin
          t0_q    <= t1_q;
          t1_q    <= t0_q - qt_w[B+1:0];
          state_q <= S_ECHK;
        end
        S_EEND: begin
          if (r0_q != B'(1)) begin
            fail_q  <= 1'b1;
            state_q <= S_PEND;
          end else begin
            mul_go_q <= 1'b1;
            mul_a_q  <= cof_q;
            mul_b_q  <= inv_w;
            state_q  <= S_WMULW;
          end
        end
        S_WMULW: begin
          if (mul_done) begin
            w_q[i_q[WIW-1:0]] <= mul_prod;
            i_q               <= i_q + 1'b1;
            state_q           <= S_COFDIV;
          end
        end
        S_PEND: begin
          wv_q    <= 1'b1;
          cf_q    <= fail_q;
          i_q     <= '0;
          acc_q   <= '0;
          state_q <= S_MLOAD;
        end
        // weighted sum mod product, a doubling state and an add state per residue bit
        S_MLOAD: begin
          if (cf_q) begin
            acc_q   <= '0;
            err_q   <= 1'b1;
            state_q <= S_FIN;
          end else if (i_q == n_w) begin
            err_q   <= 1'b0;
            state_q <= S_FIN;
          end else begin
            t_q     <= '0;
            k_q     <= KW'(BASE_BITS - 1);
            state_q <= S_MDBL;
          end
        end
        S_MDBL: begin
          t_q     <= add_mod(t_q, t_q, prod_q);
          state_q <= S_MADD;
        end
        S_MADD: begin
          if (rbit_w) t_q <= add_mod(t_q, w_w, prod_q);
          if (k_q == '0) begin
            state_q <= S_MSUM;
          end else begin
            k_q     <= k_q - 1'b1;
            state_q <= S_MDBL;
          end
        end
        S_MSUM: begin
          acc_q   <= add_mod(acc_q, t_q, prod_q);
          i_q     <= i_q + 1'b1;
          state_q <= S_MLOAD;
        end
        S_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.value <= acc_q;
            out_q.error <= err_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // error words carry a zero value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.error |-> out_data_o.value == '0)
    else $error("error word with nonzero value");

  // a good word lies below the product
  a_below_prod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.error && state_q == S_IDLE |-> out_data_o.value < prod_q)
    else $error("value not reduced");

  // the divider is never started on a zero divisor
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_go_q |-> div_dvs_q != '0)
    else $error("division by zero");

  // an accepted word blocks the input until it is finished
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

endmodule
